FILE: rtl/uudls_pkg.sv
package uudls_pkg;

   // running byte count width and the width shown on the result channel
   localparam int COUNT_BITS = 32;
   localparam int SHOWN_BITS = 32;

   // job queue between front and back
   localparam int Q_DEPTH     = 4;
   localparam int Q_ADDR_BITS = $clog2(Q_DEPTH);

   // character constants
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] SEXTET_MASK = 8'o077;

   // one classified character that yields results
   typedef struct packed {
      logic [2:0][7:0]       bytes;
      logic [1:0]            cnt;
      logic                  done;
      logic [COUNT_BITS-1:0] base;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

FILE: rtl/uudls_front.sv
module uudls_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_char_in,
   input  logic                      req_start_part,
   input  logic                      csr_valid,
   input  logic                      csr_measure_only,
   input  uudls_pkg::fifo_status_type q_status,
   output logic                      q_push,
   output uudls_pkg::job_type        q_job
);
   import uudls_pkg::*;

   typedef enum logic [1:0] {
      PH_LINE = 2'd0,
      PH_DATA = 2'd1,
      PH_SKIP = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic signed [6:0]     remaining_ff, remaining_in;
   logic [1:0]            group_pos_ff, group_pos_in;
   logic [2:0][5:0]       held_ff, held_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  measure_only_ff, measure_only_in;

   logic                  accept;
   logic [7:0]            diff;
   logic [5:0]            sx;
   logic                  is_term;
   phase_type             eff_phase;
   logic [1:0]            eff_gpos;
   logic [COUNT_BITS-1:0] eff_total;
   logic [1:0]            cnt;
   logic                  done;
   logic                  rem_pos;
   logic                  rem_ge3;
   logic signed [6:0]     rem_dec;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // sextet and terminator decode
   assign diff    = (req_char_in - CHAR_SPACE) & SEXTET_MASK;
   assign sx      = diff[5:0];
   assign is_term = (req_char_in == CHAR_NUL) || (req_char_in == CHAR_CR) ||
                    (req_char_in == CHAR_LF);

   // start of part overrides the held state
   assign eff_phase = req_start_part ? PH_LINE : phase_ff;
   assign eff_gpos  = req_start_part ? 2'd0 : group_pos_ff;
   assign eff_total = req_start_part ? '0 : total_ff;

   assign rem_pos = !remaining_ff[6] && (remaining_ff != 7'sd0);
   assign rem_ge3 = remaining_ff >= 7'sd3;
   assign rem_dec = remaining_ff - 7'sd3;

   // line state machine
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      group_pos_in = group_pos_ff;
      held_in      = held_ff;
      total_in     = total_ff;
      cnt          = 2'd0;
      done         = 1'b0;
      if (accept) begin
         phase_in     = eff_phase;
         group_pos_in = eff_gpos;
         total_in     = eff_total;
         case (eff_phase)
            PH_LINE: begin
               if (is_term) begin
                  phase_in = PH_DONE;
                  done     = 1'b1;
               end else begin
                  remaining_in = signed'({1'b0, sx});
                  group_pos_in = 2'd0;
                  phase_in     = (sx == 6'd0) ? PH_SKIP : PH_DATA;
               end
            end
            PH_SKIP: begin
               if (req_char_in == CHAR_LF) phase_in = PH_LINE;
            end
            PH_DATA: begin
               if (is_term) begin
                  group_pos_in = 2'd0;
                  phase_in     = (req_char_in == CHAR_LF) ? PH_LINE : PH_SKIP;
               end else if (eff_gpos != 2'd3) begin
                  held_in[eff_gpos] = sx;
                  group_pos_in      = eff_gpos + 2'd1;
               end else begin
                  group_pos_in = 2'd0;
                  if (rem_pos) begin
                     cnt          = rem_ge3 ? 2'd3 : remaining_ff[1:0];
                     remaining_in = rem_dec;
                     if (rem_dec == 7'sd0) phase_in = PH_SKIP;
                  end
                  total_in = eff_total + COUNT_BITS'(cnt);
               end
            end
            default: begin
               // part finished: ignore characters
            end
         endcase
      end
   end

   // job for the back end
   always_comb begin
      q_job.bytes[0] = {held_ff[0], held_ff[1][5:4]};
      q_job.bytes[1] = {held_ff[1][3:0], held_ff[2][5:2]};
      q_job.bytes[2] = {held_ff[2][1:0], sx};
      if (measure_only_ff || done) q_job.bytes = '0;
      q_job.cnt  = cnt;
      q_job.done = done;
      q_job.base = eff_total;
   end

   assign q_push = accept && (done || (cnt != 2'd0));

   assign measure_only_in = csr_valid ? csr_measure_only : measure_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LINE;
         remaining_ff    <= 7'sd0;
         group_pos_ff    <= 2'd0;
         held_ff         <= '0;
         total_ff        <= '0;
         measure_only_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         group_pos_ff    <= group_pos_in;
         held_ff         <= held_in;
         total_ff        <= total_in;
         measure_only_ff <= measure_only_in;
      end
   end

   // checks
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into a full queue");
   a_done_no_bytes: assert property (@(posedge clock) disable iff (reset)
      q_push && q_job.done |-> q_job.cnt == 2'd0)
      else $error("part end job carries bytes");

endmodule

FILE: rtl/uudls_fifo.sv
module uudls_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  uudls_pkg::job_type         push_job,
   input  logic                       pop,
   output uudls_pkg::job_type         pop_job,
   output uudls_pkg::fifo_status_type status
);
   import uudls_pkg::*;

   job_type                mem_ff [Q_DEPTH];
   logic [Q_ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_ADDR_BITS:0]   count_ff, count_in;

   assign status.full  = count_ff == (Q_ADDR_BITS+1)'(Q_DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_job      = mem_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (Q_ADDR_BITS+1)'(Q_DEPTH))
      else $error("queue fill count out of range");

endmodule

FILE: rtl/uudls_back.sv
module uudls_back (
   input  logic                       clock,
   input  logic                       reset,
   input  uudls_pkg::fifo_status_type q_status,
   input  uudls_pkg::job_type         q_job,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic [31:0]                rsp_bytes_so_far,
   output logic                       rsp_part_done,
   output logic                       rsp_last_of_run
);
   import uudls_pkg::*;

   // job being expanded
   logic                  work_valid_ff, work_valid_in;
   logic [2:0][7:0]       work_bytes_ff, work_bytes_in;
   logic [1:0]            work_cnt_ff, work_cnt_in;
   logic [1:0]            work_idx_ff, work_idx_in;
   logic                  work_done_ff, work_done_in;
   logic [COUNT_BITS-1:0] work_total_ff, work_total_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic [SHOWN_BITS-1:0] rsp_total_ff, rsp_total_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  load_out;
   logic                  w_last;
   logic [7:0]            sel_byte;
   logic [COUNT_BITS-1:0] total_inc;

   assign load_out  = work_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign w_last    = work_done_ff || (work_idx_ff == (work_cnt_ff - 2'd1));
   assign q_pop     = !q_status.empty && (!work_valid_ff || (load_out && w_last));
   assign total_inc = work_total_ff + 1'b1;

   always_comb begin
      case (work_idx_ff)
         2'd0:    sel_byte = work_bytes_ff[0];
         2'd1:    sel_byte = work_bytes_ff[1];
         2'd2:    sel_byte = work_bytes_ff[2];
         default: sel_byte = 8'd0;
      endcase
   end

   // result stepping
   always_comb begin
      work_valid_in = work_valid_ff;
      work_bytes_in = work_bytes_ff;
      work_cnt_in   = work_cnt_ff;
      work_idx_in   = work_idx_ff;
      work_done_in  = work_done_ff;
      work_total_in = work_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = work_done_ff ? 8'd0 : sel_byte;
         rsp_total_in  = work_done_ff ? work_total_ff[SHOWN_BITS-1:0]
                                      : total_inc[SHOWN_BITS-1:0];
         rsp_done_in   = work_done_ff;
         rsp_last_in   = w_last;
         work_idx_in   = work_idx_ff + 2'd1;
         work_total_in = total_inc;
         if (w_last) work_valid_in = 1'b0;
      end
      if (q_pop) begin
         work_valid_in = 1'b1;
         work_bytes_in = q_job.bytes;
         work_cnt_in   = q_job.cnt;
         work_idx_in   = 2'd0;
         work_done_in  = q_job.done;
         work_total_in = q_job.base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      work_bytes_ff <= work_bytes_in;
      work_cnt_ff   <= work_cnt_in;
      work_idx_ff   <= work_idx_in;
      work_done_ff  <= work_done_in;
      work_total_ff <= work_total_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_bytes_so_far = rsp_total_ff;
   assign rsp_part_done    = rsp_done_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff && (rsp_byte_ff == 8'd0))
      else $error("part end transaction not marked last");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff && !work_done_ff |-> work_idx_ff < work_cnt_ff)
      else $error("byte index beyond job count");

endmodule

FILE: rtl/uudecode_line_stream_unit.sv
// uudecode line stream: one character transaction per cycle while req_ready is high,
//   one result per cycle if rsp_ready; each passes job queue, work and output registers
// throughput: one character per cycle; a group character with three bytes holds the
//   back end for three bytes, absorbed by the four-entry queue (full queue stalls req)
// reset: synchronous, clears line state, byte count, queue and measure_only; no sweep
module uudecode_line_stream_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_start_part,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_bytes_so_far,
   output logic        rsp_part_done,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_measure_only
);
   import uudls_pkg::*;

   fifo_status_type q_status;
   job_type         push_job;
   job_type         pop_job;
   logic            q_push;
   logic            q_pop;

   // configuration always taken
   assign csr_ready = 1'b1;

   // front: classify characters
   uudls_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_start_part   (req_start_part),
      .csr_valid        (csr_valid),
      .csr_measure_only (csr_measure_only),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   // job queue
   uudls_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   // back: emit result transactions
   uudls_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_job            (pop_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_bytes_so_far (rsp_bytes_so_far),
      .rsp_part_done    (rsp_part_done),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
